>>> rtl/core/assert_macros.svh
// Assertion macros shared by the RTL. Synthesis sees empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Condition must hold whenever the block is out of reset.
`define KVLT_ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) else $error(msg);

// When the antecedent holds, the consequent must hold in the same cycle.
`define KVLT_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

`else

`define KVLT_ASSERT_ALWAYS(lbl, clk, rstn, cond, msg)
`define KVLT_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

>>> rtl/core/kvlt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package kvlt_pkg;

    // Default depth of the trailing-whitespace hold.
    localparam int MAX_HELD_WS_DEF = 16;

    // Depth of the command queue between front and back.
    localparam int CMD_DEPTH = 4;

    // Character codes.
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_EQUAL = 8'h3d;

    // Role codes on the result channel.
    localparam logic [1:0] ROLE_KEY   = 2'd0;
    localparam logic [1:0] ROLE_VALUE = 2'd1;
    localparam logic [1:0] ROLE_END   = 2'd2;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic [1:0] role;
        logic       has_value;
        logic       last_of_run;
    } out_item_t;

    // Body action of one command.
    typedef enum logic [2:0] {
        ACT_NONE  = 3'd0,
        ACT_KEY   = 3'd1,
        ACT_VALUE = 3'd2,
        ACT_FLUSH = 3'd3,
        ACT_HOLD  = 3'd4
    } act_t;

    typedef struct packed {
        logic [7:0] ch;
        act_t       act;
        logic       close;
        logic       close_hv;
    } cmd_t;

endpackage

`default_nettype wire

>>> rtl/core/kvlt_front.sv
`timescale 1ns / 1ps
`default_nettype none

module kvlt_front
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             text_valid,
    output logic                  text_ready,
    input  wire kvlt_pkg::in_item_t text,
    output kvlt_pkg::cmd_t        cmd,
    output logic                  cmd_push,
    input  wire logic             cmd_full
);

    typedef enum logic [4:0] {
        PH_LINE    = 5'b00001,
        PH_COMMENT = 5'b00010,
        PH_KEY     = 5'b00100,
        PH_SEP     = 5'b01000,
        PH_VALUE   = 5'b10000
    } phase_t;

    phase_t     phase_reg;
    phase_t     phase_next;
    logic [7:0] c;
    logic       is_eol;
    logic       is_ws;
    logic       is_sep;
    logic       is_hash;
    logic       take;

    assign c       = text.text_byte;
    assign is_eol  = (c == kvlt_pkg::CH_LF) || (c == kvlt_pkg::CH_CR) ||
                     (c == kvlt_pkg::CH_NUL);
    assign is_ws   = (c == kvlt_pkg::CH_SPACE) || (c == kvlt_pkg::CH_TAB);
    assign is_sep  = is_ws || (c == kvlt_pkg::CH_COLON) || (c == kvlt_pkg::CH_EQUAL);
    assign is_hash = (c == kvlt_pkg::CH_HASH);

    assign text_ready = !cmd_full;
    assign take       = text_valid && text_ready;

    always_comb
    begin
        phase_next   = phase_reg;
        cmd.ch       = c;
        cmd.act      = kvlt_pkg::ACT_NONE;
        cmd.close    = 1'b0;
        cmd.close_hv = 1'b0;
        case (phase_reg)
            PH_LINE:
            begin
                if (is_hash)
                begin
                    phase_next = PH_COMMENT;
                end
                else if (!is_ws && !is_eol)
                begin
                    cmd.act    = kvlt_pkg::ACT_KEY;
                    phase_next = PH_KEY;
                end
            end
            PH_KEY:
            begin
                if (is_eol || is_hash)
                begin
                    cmd.close  = 1'b1;
                    phase_next = is_hash ? PH_COMMENT : PH_LINE;
                end
                else if (is_sep)
                begin
                    phase_next = PH_SEP;
                end
                else
                begin
                    cmd.act = kvlt_pkg::ACT_KEY;
                end
            end
            PH_SEP:
            begin
                if (is_eol || is_hash)
                begin
                    cmd.close  = 1'b1;
                    phase_next = is_hash ? PH_COMMENT : PH_LINE;
                end
                else if (!is_sep)
                begin
                    cmd.act    = kvlt_pkg::ACT_VALUE;
                    phase_next = PH_VALUE;
                end
            end
            PH_VALUE:
            begin
                if (is_eol || is_hash)
                begin
                    cmd.close    = 1'b1;
                    cmd.close_hv = 1'b1;
                    phase_next   = is_hash ? PH_COMMENT : PH_LINE;
                end
                else if (is_ws)
                begin
                    cmd.act = kvlt_pkg::ACT_HOLD;
                end
                else
                begin
                    cmd.act = kvlt_pkg::ACT_FLUSH;
                end
            end
            default:
            begin
                if (is_eol || (phase_reg != PH_COMMENT))
                begin
                    phase_next = PH_LINE;
                end
            end
        endcase

        // The final byte closes any open record.
        if (text.end_of_text)
        begin
            if ((phase_next == PH_KEY) || (phase_next == PH_SEP))
            begin
                cmd.close = 1'b1;
            end
            else if (phase_next == PH_VALUE)
            begin
                cmd.close    = 1'b1;
                cmd.close_hv = 1'b1;
            end
            phase_next = PH_LINE;
        end
    end

    // Bytes that change nothing downstream are not queued.
    assign cmd_push = take && ((cmd.act != kvlt_pkg::ACT_NONE) || cmd.close);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LINE;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/kvlt_cmd_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module kvlt_cmd_queue
#(
    parameter int DEPTH = kvlt_pkg::CMD_DEPTH
)
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire kvlt_pkg::cmd_t push_cmd,
    output logic                full,
    input  wire logic           pop,
    output logic                head_valid,
    output kvlt_pkg::cmd_t      head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    kvlt_pkg::cmd_t   slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             do_push;
    logic             do_pop;

    assign full       = (cnt_reg == CNT_W'(DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/kvlt_back.sv
`timescale 1ns / 1ps
`default_nettype none

module kvlt_back
#(
    parameter int MAX_HELD_WS = kvlt_pkg::MAX_HELD_WS_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cmd_valid,
    input  wire kvlt_pkg::cmd_t    cmd,
    output logic                   cmd_pop,
    output logic                   rec_valid,
    input  wire logic              rec_ready,
    output kvlt_pkg::out_item_t    rec
);

    localparam int CNT_W = $clog2(MAX_HELD_WS + 1);

    typedef enum logic [1:0] {
        BK_BODY  = 2'b01,
        BK_CLOSE = 2'b10
    } bk_state_t;

    bk_state_t            state_reg;
    bk_state_t            state_next;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     cnt_next;
    logic [MAX_HELD_WS-1:0] held_reg;
    logic [MAX_HELD_WS-1:0] held_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    kvlt_pkg::out_item_t  out_reg;
    kvlt_pkg::out_item_t  res;
    logic                 emit;
    logic                 body_done;
    logic                 adv;
    logic                 new_tab;
    logic [7:0]           oldest_char;

    // A held entry of 1 stands for a tab, 0 for a space.
    assign new_tab     = (cmd.ch == kvlt_pkg::CH_TAB);
    assign oldest_char = held_reg[0] ? kvlt_pkg::CH_TAB : kvlt_pkg::CH_SPACE;
    assign adv         = !out_valid_reg || rec_ready;

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        held_next       = held_reg;
        out_valid_next  = out_valid_reg && !rec_ready;
        cmd_pop         = 1'b0;
        emit            = 1'b0;
        body_done       = 1'b0;
        res.out_char    = cmd.ch;
        res.role        = kvlt_pkg::ROLE_VALUE;
        res.has_value   = 1'b0;
        res.last_of_run = 1'b0;
        if (cmd_valid && adv)
        begin
            case (state_reg)
                BK_BODY:
                begin
                    case (cmd.act)
                        kvlt_pkg::ACT_KEY:
                        begin
                            emit      = 1'b1;
                            res.role  = kvlt_pkg::ROLE_KEY;
                            body_done = 1'b1;
                        end
                        kvlt_pkg::ACT_VALUE:
                        begin
                            emit      = 1'b1;
                            cnt_next  = '0;
                            body_done = 1'b1;
                        end
                        kvlt_pkg::ACT_FLUSH:
                        begin
                            emit = 1'b1;
                            if (cnt_reg != '0)
                            begin
                                // Release the oldest held blank, one per cycle while the result channel accepts beats.
                                res.out_char = oldest_char;
                                held_next    = held_reg >> 1;
                                cnt_next     = cnt_reg - 1'b1;
                            end
                            else
                            begin
                                body_done = 1'b1;
                            end
                        end
                        kvlt_pkg::ACT_HOLD:
                        begin
                            body_done = 1'b1;
                            if (cnt_reg == CNT_W'(MAX_HELD_WS))
                            begin
                                // Hold is full: the oldest blank goes out.
                                emit                       = 1'b1;
                                res.out_char               = oldest_char;
                                held_next                  = held_reg >> 1;
                                held_next[MAX_HELD_WS - 1] = new_tab;
                            end
                            else
                            begin
                                for (int i = 0; i < MAX_HELD_WS; i++)
                                begin
                                    if (cnt_reg == CNT_W'(i))
                                    begin
                                        held_next[i] = new_tab;
                                    end
                                end
                                cnt_next = cnt_reg + 1'b1;
                            end
                        end
                        default:
                        begin
                            body_done = 1'b1;
                        end
                    endcase

                    if (body_done)
                    begin
                        if (!cmd.close)
                        begin
                            res.last_of_run = 1'b1;
                            cmd_pop         = 1'b1;
                        end
                        else if (emit)
                        begin
                            state_next = BK_CLOSE;
                        end
                        else
                        begin
                            // Nothing from the body, so the record end goes now.
                            emit            = 1'b1;
                            res.out_char    = '0;
                            res.role        = kvlt_pkg::ROLE_END;
                            res.has_value   = cmd.close_hv;
                            res.last_of_run = 1'b1;
                            cnt_next        = '0;
                            cmd_pop         = 1'b1;
                        end
                    end
                end
                BK_CLOSE:
                begin
                    emit            = 1'b1;
                    res.out_char    = '0;
                    res.role        = kvlt_pkg::ROLE_END;
                    res.has_value   = cmd.close_hv;
                    res.last_of_run = 1'b1;
                    cnt_next        = '0;
                    cmd_pop         = 1'b1;
                    state_next      = BK_BODY;
                end
                default:
                begin
                    state_next = BK_BODY;
                end
            endcase
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_BODY;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_reg <= held_next;
        if (emit)
        begin
            out_reg <= res;
        end
    end

    assign rec_valid = out_valid_reg;
    assign rec       = out_reg;

endmodule

`default_nettype wire

>>> rtl/core/key_value_line_tokenizer.sv
// Commands pass through a four-entry command queue that absorbs bursts; the back end
// registers each result beat. The front end takes one byte per cycle while the queue is
// not full. A value character after n held blanks comes out as the n blanks and then
// the character, and a record end that follows a character is a beat of its own.
// Reset: rst_n is asynchronous, active low; it clears the parse phase, the queue, the
// held-blank count and the output valid. The held-blank store itself is not reset.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module key_value_line_tokenizer
#(
    parameter int MAX_HELD_WS = kvlt_pkg::MAX_HELD_WS_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                text_valid,
    output logic                     text_ready,
    input  wire kvlt_pkg::in_item_t  text,
    output logic                     rec_valid,
    input  wire logic                rec_ready,
    output kvlt_pkg::out_item_t      rec
);

    // The front end runs the line parser at one beat per cycle while the queue has room
    // and turns each byte into at most one command. Bytes that only move the parser along,
    // such as leading blanks, separators and comment text, produce no command at all.
    kvlt_pkg::cmd_t front_cmd;
    logic           front_push;
    logic           queue_full;

    // The back end owns the held-blank store and expands commands into result beats.
    kvlt_pkg::cmd_t head_cmd;
    logic           head_valid;
    logic           head_pop;

    kvlt_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_valid (text_valid),
        .text_ready (text_ready),
        .text       (text),
        .cmd        (front_cmd),
        .cmd_push   (front_push),
        .cmd_full   (queue_full)
    );

    kvlt_cmd_queue #(
        .DEPTH (kvlt_pkg::CMD_DEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (front_push),
        .push_cmd   (front_cmd),
        .full       (queue_full),
        .pop        (head_pop),
        .head_valid (head_valid),
        .head       (head_cmd)
    );

    // The output register inside the back end holds the current result beat; the back end
    // moves on to the next command only once that beat is taken or the register is empty.
    kvlt_back #(
        .MAX_HELD_WS (MAX_HELD_WS)
    ) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (head_valid),
        .cmd       (head_cmd),
        .cmd_pop   (head_pop),
        .rec_valid (rec_valid),
        .rec_ready (rec_ready),
        .rec       (rec)
    );

    // A record end always carries a zero character and always closes its run.
    `KVLT_ASSERT_IMP(a_end_char_zero, clk, rst_n,
        rec_valid && (rec.role == kvlt_pkg::ROLE_END), rec.out_char == 8'd0,
        "record end with non-zero character")
    `KVLT_ASSERT_IMP(a_end_is_last, clk, rst_n,
        rec_valid && (rec.role == kvlt_pkg::ROLE_END), rec.last_of_run,
        "record end not marked as last of run")
    // Only record ends may report a value.
    `KVLT_ASSERT_IMP(a_hv_only_on_end, clk, rst_n,
        rec_valid && (rec.role != kvlt_pkg::ROLE_END), !rec.has_value,
        "has_value set on a character beat")
    `KVLT_ASSERT_ALWAYS(a_role_legal, clk, rst_n,
        !rec_valid || (rec.role <= kvlt_pkg::ROLE_END),
        "reserved role code on the result channel")

endmodule

`default_nettype wire
